// ===== hdl/stg_pkg.sv =====
// Shared package for the sweep tone generator: sizes, register map, codes,
// configuration and command structs, and the quarter-wave sine table.
// Depends on nothing; every other file but stg_checker imports it.
package stg_pkg;

    // Sizes of the design.
    localparam int SAMPLES_PER_FRAME = 480;
    localparam int SINE_TABLE_DEPTH  = 1024;   // power of two
    localparam int PHASE_BITS        = 32;

    localparam int IDX_W   = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
    localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_AW  = SINE_AW + 1;

    // Command queue between the front and the back end.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_AW = 3;

    localparam logic [REG_AW-1:0] REG_MODE       = 3'd0;
    localparam logic [REG_AW-1:0] REG_OSC_TYPE   = 3'd1;
    localparam logic [REG_AW-1:0] REG_TONE_INC   = 3'd2;
    localparam logic [REG_AW-1:0] REG_START_INC  = 3'd3;
    localparam logic [REG_AW-1:0] REG_STOP_INC   = 3'd4;
    localparam logic [REG_AW-1:0] REG_SWEEP_RAT  = 3'd5;
    localparam logic [REG_AW-1:0] REG_HOLD_FRM   = 3'd6;
    localparam logic [REG_AW-1:0] REG_AMPLITUDE  = 3'd7;

    // Mode and oscillator codes.
    localparam logic [1:0] MODE_SWEEP = 2'd1;
    localparam logic [1:0] OSC_SQUARE = 2'd1;
    localparam logic [1:0] OSC_NOISE  = 2'd3;

    // Reset values of the registers and of the increment.
    localparam logic [30:0] RST_TONE_INC  = 31'd4473924;
    localparam logic [30:0] RST_START_INC = 31'd4473924;
    localparam logic [30:0] RST_STOP_INC  = 31'd1789569707;
    localparam logic [16:0] RST_SWEEP_RAT = 17'd66355;
    localparam logic [15:0] RST_HOLD_FRM  = 16'd1920;
    localparam logic [14:0] RST_AMPLITUDE = 15'd16384;
    localparam logic [31:0] RST_STEP      = 32'd4473924;

    localparam logic [15:0] FULL_SCALE = 16'h7FFF;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  osc_type;
        logic [30:0] tone_increment;
        logic [30:0] start_increment;
        logic [30:0] stop_increment;
        logic [16:0] sweep_ratio;
        logic [15:0] hold_frames;
        logic [14:0] amplitude;
    } t_cfg;

    typedef struct packed {
        logic [15:0] noise_hi;
        logic        frame_start;
        logic        frame_last;
    } t_cmd;

    typedef logic [14:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    // Taylor step, two Q30 multiplies; caller divides by factorial ratio.
    function automatic logic [63:0] f_taylor_mul(input logic [63:0] t, input logic [63:0] x);
        logic [63:0] r;
        r = (t * x) >> 30;
        r = (r * x) >> 30;
        return r;
    endfunction

    // sin(pi/2 * k / depth) in Q15, series to x^11 in Q30 with truncation.
    function automatic logic [14:0] f_sine_q15(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        t;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x   = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        sum = $signed(x);
        t   = f_taylor_mul(x, x) / 64'd6;
        sum = sum - $signed(t);
        t   = f_taylor_mul(t, x) / 64'd20;
        sum = sum + $signed(t);
        t   = f_taylor_mul(t, x) / 64'd42;
        sum = sum - $signed(t);
        t   = f_taylor_mul(t, x) / 64'd72;
        sum = sum + $signed(t);
        t   = f_taylor_mul(t, x) / 64'd110;
        sum = sum - $signed(t);
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    function automatic t_sine_tab f_build_sine_tab();
        t_sine_tab tab;
        for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            tab[k] = f_sine_q15(k);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_sine_tab();

endpackage

// ===== hdl/stg_regs.sv =====
// Configuration register file of the sweep tone generator, APB-style port.
// Depends on stg_pkg for the register map, reset values and t_cfg.
module stg_regs
    import stg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready,
    output t_cfg              o_cfg
);

    t_cfg              r_cfg;
    logic              w_wr;
    logic [REG_AW-1:0] w_idx;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_idx    = i_paddr[APB_AW-1:2];
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    // Register writes, keeping only each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= '0;
            r_cfg.osc_type        <= '0;
            r_cfg.tone_increment  <= RST_TONE_INC;
            r_cfg.start_increment <= RST_START_INC;
            r_cfg.stop_increment  <= RST_STOP_INC;
            r_cfg.sweep_ratio     <= RST_SWEEP_RAT;
            r_cfg.hold_frames     <= RST_HOLD_FRM;
            r_cfg.amplitude       <= RST_AMPLITUDE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:      r_cfg.mode            <= i_pwdata[1:0];
                REG_OSC_TYPE:  r_cfg.osc_type        <= i_pwdata[1:0];
                REG_TONE_INC:  r_cfg.tone_increment  <= i_pwdata[30:0];
                REG_START_INC: r_cfg.start_increment <= i_pwdata[30:0];
                REG_STOP_INC:  r_cfg.stop_increment  <= i_pwdata[30:0];
                REG_SWEEP_RAT: r_cfg.sweep_ratio     <= i_pwdata[16:0];
                REG_HOLD_FRM:  r_cfg.hold_frames     <= i_pwdata[15:0];
                REG_AMPLITUDE: r_cfg.amplitude       <= i_pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        o_prdata = '0;
        unique case (w_idx)
            REG_MODE:      o_prdata = APB_DW'(r_cfg.mode);
            REG_OSC_TYPE:  o_prdata = APB_DW'(r_cfg.osc_type);
            REG_TONE_INC:  o_prdata = APB_DW'(r_cfg.tone_increment);
            REG_START_INC: o_prdata = APB_DW'(r_cfg.start_increment);
            REG_STOP_INC:  o_prdata = APB_DW'(r_cfg.stop_increment);
            REG_SWEEP_RAT: o_prdata = APB_DW'(r_cfg.sweep_ratio);
            REG_HOLD_FRM:  o_prdata = APB_DW'(r_cfg.hold_frames);
            REG_AMPLITUDE: o_prdata = APB_DW'(r_cfg.amplitude);
            default:       o_prdata = '0;
        endcase
    end

endmodule

// ===== hdl/stg_front.sv =====
// Front end: accepts sample requests, tracks the position in the frame and
// tags each beat with frame start and frame end. Depends on stg_pkg.
module stg_front
    import stg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [31:0] i_noise_in,
    input  logic        i_q_full,
    output logic        o_q_wr,
    output t_cmd        o_q_cmd
);

    logic [IDX_W-1:0] r_index;
    logic [IDX_W-1:0] n_index;
    logic             w_last;

    assign w_last              = (r_index == IDX_W'(SAMPLES_PER_FRAME - 1));
    assign o_q_wr              = i_push && !i_q_full;
    assign o_q_cmd.noise_hi    = i_noise_in[31:16];
    assign o_q_cmd.frame_start = (r_index == '0);
    assign o_q_cmd.frame_last  = w_last;

    // Sample position within the frame, wrapping after the last sample.
    always_comb begin
        n_index = r_index;
        if (o_q_wr) begin
            n_index = w_last ? '0 : r_index + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

endmodule

// ===== hdl/stg_cmd_q.sv =====
// Short command queue between the front and the back end of the generator.
// Depends on stg_pkg for t_cmd and the queue depth.
module stg_cmd_q
    import stg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_cmd,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_rd_cmd,
    output logic o_empty
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_AW:0]   r_count;

    assign o_full   = (r_count == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/stg_back.sv =====
// Back end: frame-start increment update, sine lookup, oscillator shaping,
// amplitude scaling and the result register. Depends on stg_pkg.
module stg_back
    import stg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_q_cmd,
    input  logic        i_q_empty,
    output logic        o_q_rd,
    output logic [15:0] o_sample,
    output logic        o_frame_last,
    output logic        o_empty,
    input  logic        i_pop
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_STEP  = 6'b000100,
        ST_LOOK  = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    t_cmd                  r_cmd;
    logic [PHASE_BITS-1:0] r_phase;
    logic [31:0]           r_step;
    logic [16:0]           r_count;
    logic                  r_gate;
    logic [48:0]           r_prod;
    logic [14:0]           r_tab;
    logic [1:0]            r_quad;
    logic [15:0]           r_mag;
    logic                  r_neg;
    logic                  r_out_valid;
    logic [15:0]           r_out_sample;
    logic                  r_out_last;

    logic                  w_sweep;
    logic [31:0]           w_sat;
    logic [31:0]           w_new_step;
    logic [SINE_AW-1:0]    w_fine;
    logic [ROM_AW-1:0]     w_addr;
    logic [15:0]           w_src_mag;
    logic                  w_src_neg;
    logic [30:0]           w_scaled;
    logic                  w_out_free;

    assign w_sweep    = (i_cfg.mode == MODE_SWEEP);
    assign w_out_free = !r_out_valid || i_pop;
    assign o_q_rd     = (r_state == ST_IDLE) && !i_q_empty;

    // Next state of the per-item sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_cmd.frame_start ? ST_MUL : ST_LOOK;
                end
            end
            ST_MUL:   n_state = ST_STEP;
            ST_STEP:  n_state = ST_LOOK;
            ST_LOOK:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Saturated Q16 product and the increment chosen at frame start.
    assign w_sat = r_prod[48] ? 32'hFFFF_FFFF : r_prod[47:16];
    always_comb begin
        if (!w_sweep) begin
            w_new_step = {1'b0, i_cfg.tone_increment};
        end else if (r_count == '0) begin
            w_new_step = {1'b0, i_cfg.start_increment};
        end else begin
            w_new_step = w_sat;
        end
    end

    // Quarter-wave table address: mirrored in the second and fourth quadrant.
    assign w_fine = r_phase[PHASE_BITS-3 -: SINE_AW];
    assign w_addr = r_phase[PHASE_BITS-2]
                  ? ROM_AW'(SINE_TABLE_DEPTH) - {1'b0, w_fine}
                  : {1'b0, w_fine};

    // Magnitude and sign of the source value for the selected oscillator.
    always_comb begin
        if (i_cfg.osc_type == OSC_NOISE) begin
            w_src_neg = !r_cmd.noise_hi[15];
            w_src_mag = r_cmd.noise_hi[15] ? {1'b0, r_cmd.noise_hi[14:0]}
                                           : 16'h8000 - r_cmd.noise_hi;
        end else begin
            w_src_neg = r_quad[1] && (r_tab != '0);
            w_src_mag = (i_cfg.osc_type == OSC_SQUARE) ? FULL_SCALE : {1'b0, r_tab};
        end
    end

    assign w_scaled = w_src_mag * i_cfg.amplitude;

    // Control state: sequencer, phase, increment, sweep counter and gate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_step  <= RST_STEP;
            r_count <= '0;
            r_gate  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_STEP) begin
                r_step <= w_new_step;
                if (!w_sweep) begin
                    r_gate <= 1'b1;
                end else if (w_new_step > {1'b0, i_cfg.stop_increment}) begin
                    r_gate  <= 1'b0;
                    r_count <= (r_count > {1'b0, i_cfg.hold_frames}) ? '0 : r_count + 1'b1;
                end else begin
                    if (r_count == '0) begin
                        r_gate <= 1'b1;
                    end
                    r_count <= r_count + 1'b1;
                end
            end
            if (r_state == ST_LOOK) begin
                r_phase <= r_phase + PHASE_BITS'(r_step);
            end
        end
    end

    // Datapath registers of the item in flight.
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == ST_MUL) begin
            r_prod <= 49'(r_step) * 49'(i_cfg.sweep_ratio);
        end
        if (r_state == ST_LOOK) begin
            r_tab  <= SINE_TAB[w_addr];
            r_quad <= r_phase[PHASE_BITS-1 -: 2];
        end
        if (r_state == ST_SCALE) begin
            r_mag <= r_gate ? w_scaled[30:15] : '0;
            r_neg <= r_gate && w_src_neg;
        end
    end

    // Result register: holds one finished sample until it is popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_sample <= r_neg ? 16'(-r_mag) : r_mag;
            r_out_last   <= r_cmd.frame_last;
        end
    end

    assign o_sample     = r_out_sample;
    assign o_frame_last = r_out_last;
    assign o_empty      = !r_out_valid;

endmodule

// ===== hdl/sweep_tone_generator_core.sv =====
// Top level of the sweep tone generator: register file, front end,
// command queue and back end. Depends on stg_pkg and the stg_* modules.
//
//   channel   handshake              payload
//   request   push / full            i_noise_in
//   result    empty / pop            o_sample, o_frame_last
//   config    psel penable pwrite    paddr, pwdata, prdata, pready
//
// The back end steps a sample through queue read, table read, scaling and
// result write; the first sample of a frame also passes a multiply and an
// increment update before the table read. The back-end sequencer sets the
// rate and holds in result write while a result waits; the front end still
// takes requests while the two-entry command queue has room.
// Reset is synchronous and active low; all queues start empty.
module sweep_tone_generator_core
    import stg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [31:0]       i_noise_in,
    output logic              empty,
    input  logic              pop,
    output logic [15:0]       o_sample,
    output logic              o_frame_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;
    t_cmd w_wr_cmd;
    t_cmd w_rd_cmd;
    logic w_q_wr;
    logic w_q_rd;
    logic w_q_full;
    logic w_q_empty;

    assign full = w_q_full;

    // Configuration registers.
    stg_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    // Request intake and frame tagging.
    stg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_noise_in (i_noise_in),
        .i_q_full   (w_q_full),
        .o_q_wr     (w_q_wr),
        .o_q_cmd    (w_wr_cmd)
    );

    // Decoupling queue.
    stg_cmd_q u_cmd_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_q_wr),
        .i_wr_cmd (w_wr_cmd),
        .o_full   (w_q_full),
        .i_rd     (w_q_rd),
        .o_rd_cmd (w_rd_cmd),
        .o_empty  (w_q_empty)
    );

    // Sample generation and result register.
    stg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_cmd      (w_rd_cmd),
        .i_q_empty    (w_q_empty),
        .o_q_rd       (w_q_rd),
        .o_sample     (o_sample),
        .o_frame_last (o_frame_last),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

// ===== hdl/stg_checker.sv =====
// Port-level checker for the sweep tone generator, bound to the top level.
// Depends on the port list of sweep_tone_generator_core.
module stg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_sample,
    input logic        o_frame_last,
    input logic        pready
);

    logic [2:0] r_outstanding;

    // Requests accepted whose result beat has not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            case ({push && !full, pop && !empty})
                2'b10:   r_outstanding <= r_outstanding + 1'b1;
                2'b01:   r_outstanding <= r_outstanding - 1'b1;
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    // A waiting result beat holds until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sample) && $stable(o_frame_last)))
        else $error("result beat changed before it was popped");

    // No result beat is left over from before reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result shown straight after reset");

    // Every result beat belongs to an accepted request.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_outstanding != 3'd0))
        else $error("result beat without an outstanding request");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind sweep_tone_generator_core stg_checker u_stg_checker (.*);
